>>> sv/ltg_pkg.sv
// ----------------------------------------------------------------------------
// ltg_pkg
// Shared types and constants for the load throttle governor.
// ----------------------------------------------------------------------------
package ltg_pkg;

  localparam int HIST_DEPTH_DEF = 16;

  localparam int LOAD_W  = 10;
  localparam int MEM_W   = 16;
  localparam int PHASE_W = 8;
  localparam int THR_W   = 9;

  localparam logic [MEM_W-1:0] HW_RESET = MEM_W'(768);

  // q1.8 throttle levels
  localparam logic [THR_W-1:0] Q_TENTH = THR_W'(26);
  localparam logic [THR_W-1:0] Q_03    = THR_W'(77);
  localparam logic [THR_W-1:0] Q_06    = THR_W'(154);
  localparam logic [THR_W-1:0] Q_085   = THR_W'(218);
  localparam logic [THR_W-1:0] Q_ONE   = THR_W'(256);

  // load thresholds in tenths of a percent
  localparam logic [LOAD_W-1:0] LOAD_LVL4 = LOAD_W'(900);
  localparam logic [LOAD_W-1:0] LOAD_LVL3 = LOAD_W'(800);
  localparam logic [LOAD_W-1:0] LOAD_LVL2 = LOAD_W'(700);
  localparam logic [LOAD_W-1:0] LOAD_LVL1 = LOAD_W'(500);

  localparam logic [PHASE_W-1:0] SLEEP_LEVEL = PHASE_W'(77);

  // 85% mark as 20*used >= 17*hw
  localparam int MARK_W = MEM_W + 5;
  localparam logic [MARK_W-1:0] MARK_USED_MUL = MARK_W'(20);
  localparam logic [MARK_W-1:0] MARK_HW_MUL   = MARK_W'(17);

  typedef struct packed {
    logic [LOAD_W-1:0]  load_sample;
    logic [MEM_W-1:0]   mem_used;
    logic [PHASE_W-1:0] day_phase;
  } in_item_t;

  typedef struct packed {
    logic [THR_W-1:0]  combined_throttle;
    logic [THR_W-1:0]  load_throttle;
    logic [THR_W-1:0]  memory_throttle;
    logic [THR_W-1:0]  train_brake;
    logic [LOAD_W-1:0] load_average;
  } out_item_t;

endpackage

>>> sv/ltg_ring.sv
// ----------------------------------------------------------------------------
// ltg_ring
// Sample history memory with running sum and nonzero count of its entries.
// ----------------------------------------------------------------------------
module ltg_ring
  import ltg_pkg::*;
#(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
  parameter int SLOT_W        = $clog2(HISTORY_DEPTH),
  parameter int CNT_W         = $clog2(HISTORY_DEPTH + 1),
  parameter int SUM_W         = LOAD_W + CNT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LOAD_W-1:0] sample,
  output logic              done,
  output logic [SUM_W-1:0]  sum,
  output logic [CNT_W-1:0]  cnt
);

  logic [LOAD_W-1:0] mem [HISTORY_DEPTH];
  logic [LOAD_W-1:0] rd_data_r;
  logic [LOAD_W-1:0] smp_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              full_r, full_nxt;
  logic              pend_r;
  logic              done_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LOAD_W-1:0] old_val;
  logic              wrap;

  // entry at the write slot holds data only once the ring has wrapped
  assign old_val = full_r ? rd_data_r : '0;
  assign wrap    = (slot_r == SLOT_W'(HISTORY_DEPTH - 1));

  always_comb begin
    slot_nxt = wrap ? '0 : slot_r + SLOT_W'(1);
    full_nxt = full_r | wrap;
    sum_nxt  = sum_r - SUM_W'(old_val) + SUM_W'(smp_r);
    cnt_nxt  = cnt_r - CNT_W'(old_val != '0) + CNT_W'(smp_r != '0);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rd_data_r <= mem[slot_r];
      smp_r     <= sample;
    end
    if (pend_r) begin
      mem[slot_r] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      full_r <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= start;
      done_r <= pend_r;
      if (pend_r) begin
        slot_r <= slot_nxt;
        full_r <= full_nxt;
        sum_r  <= sum_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  assign done = done_r;
  assign sum  = sum_r;
  assign cnt  = cnt_r;

endmodule

>>> sv/ltg_div.sv
// ----------------------------------------------------------------------------
// ltg_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ltg_div
  import ltg_pkg::*;
#(
  parameter int SUM_W = 14,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      dvd_r <= {dvd_r[SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

>>> sv/ltg_level.sv
// ----------------------------------------------------------------------------
// ltg_level
// Maps average load, memory use and day phase to the throttle item.
// ----------------------------------------------------------------------------
module ltg_level
  import ltg_pkg::*;
(
  input  logic [LOAD_W-1:0]  avg,
  input  logic [MEM_W-1:0]   mem_used,
  input  logic [MEM_W-1:0]   high_water,
  input  logic [PHASE_W-1:0] day_phase,
  output out_item_t          result
);

  logic [THR_W-1:0]  lt_raw, mt, brake_raw, lt, brake, combined;
  logic [MARK_W-1:0] used_x, hw_x;
  logic [15:0]       brake_prod;
  logic              sleep;

  always_comb begin
    if (avg > LOAD_LVL4) begin
      lt_raw = Q_TENTH;
    end else if (avg > LOAD_LVL3) begin
      lt_raw = Q_03;
    end else if (avg > LOAD_LVL2) begin
      lt_raw = Q_06;
    end else if (avg > LOAD_LVL1) begin
      lt_raw = Q_085;
    end else begin
      lt_raw = Q_ONE;
    end

    used_x = MARK_W'(mem_used) * MARK_USED_MUL;
    hw_x   = MARK_W'(high_water) * MARK_HW_MUL;
    if (mem_used >= high_water) begin
      mt = Q_03;
    end else if (used_x >= hw_x) begin
      mt = Q_06;
    end else begin
      mt = Q_ONE;
    end

    brake_raw  = (lt_raw < mt) ? lt_raw : mt;
    sleep      = (day_phase < SLEEP_LEVEL);
    brake_prod = 16'(brake_raw) * 16'(Q_03) + 16'd128;

    lt       = sleep ? (lt_raw >> 1) : lt_raw;
    brake    = sleep ? THR_W'(brake_prod[15:8]) : brake_raw;
    combined = (lt < mt) ? lt : mt;

    result.combined_throttle = combined;
    result.load_throttle     = lt;
    result.memory_throttle   = mt;
    result.train_brake       = brake;
    result.load_average      = avg;
  end

endmodule

>>> sv/load_throttle_governor.sv
// ----------------------------------------------------------------------------
// load_throttle_governor
// Load and memory throttle governor over a ring of recent load samples.
// ----------------------------------------------------------------------------
// One item is processed at a time. An accepted item passes through the
// read-modify-write of the sample memory and its running sum, the bit-serial
// divider that forms the average over SUM_W = 10 + clog2(HISTORY_DEPTH + 1)
// quotient bits (15 at the default depth of 16), the hand-on of the quotient
// and the level mapping into the output register, which waits while an
// earlier result there is not yet taken. in_ready drops after each accepted
// item and rises again once its result is in the output register; a result
// not yet taken does not hold off the acceptance of the next input item.
// Sample history starts empty after reset with no clearing pass. The
// high-water mark may be written whenever the block is idle.
// ----------------------------------------------------------------------------
module load_throttle_governor
  import ltg_pkg::*;
#(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_wr_en,
  input  logic [MEM_W-1:0] cfg_wr_data
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = LOAD_W + CNT_W;

  typedef enum logic [1:0] {S_IDLE, S_RING, S_DIV, S_OUT} state_t;

  state_t             state_r;
  logic               out_valid_r;
  out_item_t          out_item_r;
  logic [MEM_W-1:0]   hw_r;
  logic [MEM_W-1:0]   used_r;
  logic [PHASE_W-1:0] phase_r;

  logic               accept;
  logic               ring_done;
  logic [SUM_W-1:0]   ring_sum;
  logic [CNT_W-1:0]   ring_cnt;
  logic               div_done;
  logic [SUM_W-1:0]   div_q;
  logic [LOAD_W-1:0]  avg;
  out_item_t          level_res;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign avg      = (ring_cnt == '0) ? '0 : div_q[LOAD_W-1:0];

  ltg_ring #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .sample (in_item.load_sample),
    .done   (ring_done),
    .sum    (ring_sum),
    .cnt    (ring_cnt)
  );

  ltg_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ring_done),
    .dividend (ring_sum),
    .divisor  (ring_cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  ltg_level u_level (
    .avg        (avg),
    .mem_used   (used_r),
    .high_water (hw_r),
    .day_phase  (phase_r),
    .result     (level_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= HW_RESET;
    end else if (cfg_wr_en) begin
      hw_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      used_r  <= in_item.mem_used;
      phase_r <= in_item.day_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_RING;
          end
        end
        S_RING: begin
          if (ring_done) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_item_r  <= level_res;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> sv/ltg_checker.sv
// ----------------------------------------------------------------------------
// ltg_checker
// Port-level checks for the load throttle governor, bound to the top level.
// ----------------------------------------------------------------------------
module ltg_checker
  import ltg_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_combined_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.combined_throttle ==
      ((out_item.load_throttle < out_item.memory_throttle) ?
        out_item.load_throttle : out_item.memory_throttle)))
    else $error("combined throttle is not the minimum");

  a_mem_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.memory_throttle == Q_03 ||
      out_item.memory_throttle == Q_06 || out_item.memory_throttle == Q_ONE))
    else $error("memory throttle off its levels");

  a_brake_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.train_brake <= Q_ONE && out_item.load_throttle <= Q_ONE))
    else $error("throttle above one");

endmodule

bind load_throttle_governor ltg_checker u_ltg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

>>> dv/load_throttle_governor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_throttle_governor_test
// Self-checking bench for the load throttle governor. A short table of
// stimulus hits the load and memory thresholds, the sleep boundary and field
// extremes. Random phases follow, one per high-water setting, and mostly feed
// runs of one load value mixed with zero samples so the ring average lands on
// each load level edge. Each item out is checked field by field against the
// expected item of a typed table row, else a behavioral model of the sample
// ring and the throttle levels, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module load_throttle_governor_test;
  import ltg_pkg::*;

  localparam int PHASE_ITEMS  = 150;
  localparam int PHASE_COUNT  = 8;
  localparam int LONG_HOLD    = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} rx_mode_t;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_item;
  logic             cfg_wr_en;
  logic [MEM_W-1:0] cfg_wr_data;

  // model state
  logic [LOAD_W-1:0] load_hist [16] = '{default: '0};
  logic [3:0]        hist_slot = '0;
  logic [MEM_W-1:0]  hw_mark = HW_RESET;

  out_item_t   expected_throttles [$];
  dir_row_t    directed_q [$];
  int unsigned fail_count = 0;
  int unsigned items_in = 0;
  int unsigned results_out = 0;
  int unsigned sleep_items = 0;
  int unsigned hw_writes = 0;
  int unsigned burst_left = 0;
  bit          long_hold_due = 1'b0;

  dir_row_t directed_rows [19] = '{
    '{'{10'd0,    16'd0,     8'd255}, 1'b1, '{9'd256, 9'd256, 9'd256, 9'd256, 10'd0}},
    '{'{10'd1023, 16'd65535, 8'd0},   1'b1, '{9'd13,  9'd13,  9'd77,  9'd8,   10'd1023}},
    '{'{10'd0,    16'd767,   8'd76},  1'b1, '{9'd13,  9'd13,  9'd154, 9'd8,   10'd1023}},
    '{'{10'd0,    16'd768,   8'd77},  1'b1, '{9'd26,  9'd26,  9'd77,  9'd26,  10'd1023}},
    '{'{10'd0,    16'd652,   8'd255}, 1'b0, '0},
    '{'{10'd0,    16'd653,   8'd200}, 1'b0, '0},
    '{'{10'd1000, 16'd0,     8'd128}, 1'b0, '0},
    '{'{10'd901,  16'd700,   8'd0},   1'b0, '0},
    '{'{10'd900,  16'd653,   8'd76},  1'b0, '0},
    '{'{10'd801,  16'd652,   8'd77},  1'b0, '0},
    '{'{10'd800,  16'd100,   8'd1},   1'b0, '0},
    '{'{10'd701,  16'd768,   8'd255}, 1'b0, '0},
    '{'{10'd700,  16'd767,   8'd254}, 1'b0, '0},
    '{'{10'd501,  16'd0,     8'd77},  1'b0, '0},
    '{'{10'd500,  16'd65535, 8'd76},  1'b0, '0},
    '{'{10'd1,    16'h5555,  8'hAA},  1'b0, '0},
    '{'{10'd512,  16'hAAAA,  8'h55},  1'b0, '0},
    '{'{10'h2AA,  16'h8000,  8'h80},  1'b0, '0},
    '{'{10'h155,  16'd1,     8'd0},   1'b0, '0}
  };

  load_throttle_governor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t predict_throttles(input in_item_t it);
    out_item_t   r;
    int unsigned sum, cnt, avg, used, hw, lt, mt, brake, comb;
    load_hist[hist_slot] = it.load_sample;
    hist_slot = hist_slot + 4'd1;
    sum = 0;
    cnt = 0;
    foreach (load_hist[i]) begin
      if (load_hist[i] != 0) begin
        sum += load_hist[i];
        cnt++;
      end
    end
    avg = (cnt != 0) ? sum / cnt : 0;
    if (avg > 900)      lt = 26;
    else if (avg > 800) lt = 77;
    else if (avg > 700) lt = 154;
    else if (avg > 500) lt = 218;
    else                lt = 256;
    used = it.mem_used;
    hw = hw_mark;
    if (used >= hw)                mt = 77;
    else if (20 * used >= 17 * hw) mt = 154;
    else                           mt = 256;
    brake = (lt < mt) ? lt : mt;
    if (it.day_phase < 8'd77) begin
      lt = lt >> 1;
      brake = (brake * 77 + 128) >> 8;
    end
    comb = (lt < mt) ? lt : mt;
    r.combined_throttle = THR_W'(comb);
    r.load_throttle     = THR_W'(lt);
    r.memory_throttle   = THR_W'(mt);
    r.train_brake       = THR_W'(brake);
    r.load_average      = LOAD_W'(avg);
    return r;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // accepted input items
  always @(posedge clk) begin
    out_item_t pred;
    dir_row_t  row;
    if (rst_n && in_valid && in_ready) begin
      pred = predict_throttles(in_item);
      if (directed_q.size() != 0) begin
        row = directed_q.pop_front();
        if (row.typed) pred = row.want;
      end
      expected_throttles.push_back(pred);
      items_in++;
      if (in_item.day_phase < 8'd77) sleep_items++;
    end
  end

  // accepted result items
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_out++;
      if (expected_throttles.size() == 0) begin
        $error("result item with no input item pending");
        fail_count++;
      end else begin
        want = expected_throttles.pop_front();
        check_field("combined_throttle", want.combined_throttle, out_item.combined_throttle);
        check_field("load_throttle", want.load_throttle, out_item.load_throttle);
        check_field("memory_throttle", want.memory_throttle, out_item.memory_throttle);
        check_field("train_brake", want.train_brake, out_item.train_brake);
        check_field("load_average", want.load_average, out_item.load_average);
      end
    end
  end

  // receiver stall pattern
  initial begin
    int unsigned hold = 0;
    int unsigned tick = 0;
    rx_mode_t    mode = READY_ALWAYS;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        hold = LONG_HOLD;
      end
      if (tick % 96 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      tick++;
      if (hold != 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          READY_ALWAYS: out_ready <= 1'b1;
          READY_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          READY_SPARSE: out_ready <= (tick % 5 == 0);
          default:      out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("** load_throttle_governor: FAILED **");
    $finish;
  end

  task automatic offer(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_high_water(input logic [MEM_W-1:0] value);
    while (expected_throttles.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    hw_mark = value;
    hw_writes++;
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  initial begin
    in_item_t         stim;
    int unsigned      n, run_len, target, mark;
    bit               noisy;
    logic [MEM_W-1:0] hw_plan [PHASE_COUNT];
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    hw_plan = '{16'd0, 16'd65535, 16'd1, 16'd20, 16'd768,
                MEM_W'($urandom_range(200, 4000)), MEM_W'($urandom),
                MEM_W'($urandom_range(2, 100))};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      directed_q.push_back(directed_rows[i]);
      offer(directed_rows[i].stim);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      @(negedge clk) in_valid <= 1'b0;
      burst_left = 0;
      write_high_water(hw_plan[p]);
      if (p == 1) long_hold_due = 1'b1;
      mark = (17 * int'(hw_mark) + 19) / 20;
      n = 0;
      while (n < PHASE_ITEMS) begin
        // a ring full of one load value and zeros averages exactly to it
        run_len = $urandom_range(16, 24);
        noisy = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 9))
          0: target = 500;
          1: target = 501;
          2: target = 700;
          3: target = 701;
          4: target = 800;
          5: target = 801;
          6: target = 900;
          7: target = 901;
          8: target = 1023;
          default: target = $urandom_range(1, 1023);
        endcase
        for (int k = 0; k < run_len && n < PHASE_ITEMS; k++) begin
          if (noisy) stim.load_sample = LOAD_W'($urandom_range(0, 1023));
          else stim.load_sample = ($urandom_range(0, 3) == 0) ? '0 : LOAD_W'(target);
          case ($urandom_range(0, 6))
            0: stim.mem_used = hw_mark;
            1: stim.mem_used = (hw_mark == 0) ? '0 : hw_mark - 16'd1;
            2: stim.mem_used = MEM_W'(mark);
            3: stim.mem_used = (mark == 0) ? '0 : MEM_W'(mark - 1);
            4: stim.mem_used = '0;
            5: stim.mem_used = '1;
            default: stim.mem_used = MEM_W'($urandom);
          endcase
          case ($urandom_range(0, 4))
            0: stim.day_phase = 8'd76;
            1: stim.day_phase = 8'd77;
            2: stim.day_phase = 8'd0;
            3: stim.day_phase = 8'd255;
            default: stim.day_phase = PHASE_W'($urandom);
          endcase
          offer(stim);
          n++;
        end
      end
    end

    @(negedge clk) in_valid <= 1'b0;
    while (expected_throttles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d items in, %0d results checked, %0d of them in the sleep phase",
             items_in, results_out, sleep_items);
    $display("%0d high-water settings incl. 0 and 65535, one %0d-cycle output hold-off",
             hw_writes, LONG_HOLD);
    if (fail_count == 0) begin
      $display("** load_throttle_governor: PASSED **");
    end else begin
      $display("** load_throttle_governor: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ltg_pkg.sv
sv/ltg_ring.sv
sv/ltg_div.sv
sv/ltg_level.sv
sv/load_throttle_governor.sv
sv/ltg_checker.sv
dv/load_throttle_governor_test.sv
